// ===== design/vision_frame_parser_target_select_macros.svh =====
// ---------------------------------------------------------------------------
// vision frame parser assertion macros
// shared concurrent assertion helpers
// ---------------------------------------------------------------------------
`ifndef VISION_FRAME_PARSER_TARGET_SELECT_MACROS_SVH
`define VISION_FRAME_PARSER_TARGET_SELECT_MACROS_SVH

// implication checked on every edge out of reset
`define VFP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the following cycle
`define VFP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/vfp_pkg.sv =====
// ---------------------------------------------------------------------------
// vfp_pkg
// types and constants for the vision frame parser
// ---------------------------------------------------------------------------
package vfp_pkg;

  localparam logic [7:0] HDR_BYTE    = 8'h55;
  localparam logic [7:0] END_BYTE    = 8'hAA;
  localparam logic [7:0] TYPE_MULTI  = 8'h5B;
  localparam logic [7:0] TYPE_SINGLE = 8'h5A;
  localparam logic [7:0] TYPE_SCALE  = 8'h51;

  localparam int RX_BUFFER_BYTES = 128;
  localparam int MAX_TARGETS     = 3;
  localparam logic [7:0] RING_ORDER_BASE = 8'd4;
  localparam int FB_DEPTH = 16;
  localparam int IDX_W    = $clog2(RX_BUFFER_BYTES + 1);

  localparam logic [7:0] CENTER_X_RST = 8'd121;
  localparam logic [7:0] CENTER_Y_RST = 8'd115;

  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_REQ_MODE = 2'd2;
  localparam logic [1:0] REG_REQ_CLS  = 2'd3;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_MULTI  = 2'd1,
    KIND_SCALE  = 2'd2
  } kind_t;

  localparam logic [1:0] MODE_MATERIAL = 2'd1;
  localparam logic [1:0] MODE_RING     = 2'd2;

  // completed frame handed from parser to decoder
  typedef struct packed {
    kind_t      kind;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [1:0] mode;
    logic [1:0] count;
    logic [1:0] cls0;
    logic [15:0] xy0;
    logic [1:0] cls1;
    logic [15:0] xy1;
    logic [1:0] cls2;
    logic [15:0] xy2;
  } frame_t;

  typedef struct packed {
    kind_t       frame_kind;
    logic [7:0]  target_order;
    logic [7:0]  target_x;
    logic [7:0]  target_y;
    logic [8:0]  disc_dx;
    logic [8:0]  disc_dy;
    logic [8:0]  arm_dx;
    logic [8:0]  arm_dy;
    logic        offset_valid;
    logic [15:0] scale_raw;
    logic [31:0] frame_total;
  } result_t;

  localparam int OUT_BITS = $bits(result_t);
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

endpackage

// ===== design/vfp_parser.sv =====
// ---------------------------------------------------------------------------
// vfp_parser
// byte hunter and frame collector, emits one frame record per good frame
// ---------------------------------------------------------------------------
module vfp_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_valid,
  input  logic [7:0]      rx_byte,
  output logic            frm_valid,
  output vfp_pkg::frame_t frm
);
  import vfp_pkg::*;

  logic                    in_frame_r, in_frame_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [7:0]              fb_r [FB_DEPTH];
  logic [$clog2(FB_DEPTH)-1:0] wr_a;
  logic [IDX_W-1:0]        cnt;
  logic                    store;
  logic [7:0]              typ, cbyte;
  logic                    ready, drop;
  logic [IDX_W-1:0]        need;

  assign store = byte_valid && (in_frame_r || rx_byte == HDR_BYTE);
  assign wr_a  = in_frame_r ? idx_r[$clog2(FB_DEPTH)-1:0] : '0;
  assign cnt   = (in_frame_r ? idx_r : '0) + IDX_W'(1);
  // type and count may be the byte arriving now
  assign typ   = (cnt == IDX_W'(2)) ? rx_byte : fb_r[1];
  assign cbyte = (cnt == IDX_W'(4)) ? rx_byte : fb_r[3];
  assign need  = IDX_W'(5) + IDX_W'(cbyte[1:0]) * IDX_W'(3);

  always_comb begin
    ready = 1'b0;
    drop  = 1'b0;
    if (cnt >= IDX_W'(RX_BUFFER_BYTES)) begin
      drop = 1'b1;
    end else if (cnt >= IDX_W'(2)) begin
      if (typ == TYPE_MULTI) begin
        if (cnt >= IDX_W'(4)) begin
          if (cbyte > 8'(MAX_TARGETS)) drop = 1'b1;
          else ready = cnt >= need;
        end
      end else if (typ == TYPE_SINGLE || typ == TYPE_SCALE) begin
        ready = cnt >= IDX_W'(6);
      end else begin
        ready = rx_byte == END_BYTE;
      end
    end
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    idx_nxt      = idx_r;
    if (store) begin
      if (drop || ready) begin
        in_frame_nxt = 1'b0;
        idx_nxt      = '0;
      end else begin
        in_frame_nxt = 1'b1;
        idx_nxt      = cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      idx_r      <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store && cnt <= IDX_W'(FB_DEPTH)) fb_r[wr_a] <= rx_byte;
  end

  // record is built from stored bytes; the closing byte only gates frm_valid
  always_comb begin
    frm_valid = 1'b0;
    frm       = '0;
    frm.b2    = fb_r[2];
    frm.b3    = fb_r[3];
    frm.b4    = fb_r[4];
    frm.mode  = fb_r[2][1:0];
    frm.count = fb_r[3][1:0];
    frm.cls0  = fb_r[4][1:0];
    frm.xy0   = {fb_r[5], fb_r[6]};
    frm.cls1  = fb_r[7][1:0];
    frm.xy1   = {fb_r[8], fb_r[9]};
    frm.cls2  = fb_r[10][1:0];
    frm.xy2   = {fb_r[11], fb_r[12]};
    if (fb_r[4][7:2] != '0) frm.cls0 = 2'd0;
    if (fb_r[7][7:2] != '0) frm.cls1 = 2'd0;
    if (fb_r[10][7:2] != '0) frm.cls2 = 2'd0;
    if (typ == TYPE_SINGLE)     frm.kind = KIND_SINGLE;
    else if (typ == TYPE_SCALE) frm.kind = KIND_SCALE;
    else                        frm.kind = KIND_MULTI;
    if (store && ready && !drop && rx_byte == END_BYTE) begin
      if (typ == TYPE_SINGLE || typ == TYPE_SCALE) frm_valid = 1'b1;
      else if (typ == TYPE_MULTI)
        frm_valid = fb_r[2] == {6'd0, MODE_MATERIAL} || fb_r[2] == {6'd0, MODE_RING};
    end
  end

endmodule

// ===== design/vfp_queue.sv =====
// ---------------------------------------------------------------------------
// vfp_queue
// two-entry frame queue between parser and decoder
// ---------------------------------------------------------------------------
module vfp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  vfp_pkg::frame_t wr_data,
  output logic            full,
  output logic            rd_valid,
  input  logic            rd_en,
  output vfp_pkg::frame_t rd_data
);
  import vfp_pkg::*;

  frame_t     mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = cnt_r == 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule

// ===== design/vfp_decoder.sv =====
// ---------------------------------------------------------------------------
// vfp_decoder
// applies frame records to cache and selection, drives the result register
// ---------------------------------------------------------------------------
`include "vision_frame_parser_target_select_macros.svh"
module vfp_decoder (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             frm_valid,
  input  vfp_pkg::frame_t  frm,
  output logic             frm_take,
  input  logic [7:0]       center_x,
  input  logic [7:0]       center_y,
  input  logic [1:0]       request_mode,
  input  logic [1:0]       request_class,
  output logic             res_valid,
  output vfp_pkg::result_t res,
  input  logic             res_ready
);
  import vfp_pkg::*;

  logic [5:0]  cv_r, cv_nxt;
  logic [15:0] cxy_r [6];
  logic [15:0] cxy_nxt [6];
  logic [7:0]  sel_o_r, sel_x_r, sel_y_r;
  logic [8:0]  ddx_r, ddy_r, adx_r, ady_r;
  logic        ov_r;
  logic [15:0] scale_r;
  logic [31:0] total_r;
  logic [3:0]  lmc_r;
  logic        res_valid_r;
  result_t     res_r;

  logic        set_sel;
  logic [7:0]  so, sx, sy;
  logic        nz;
  logic [2:0]  base;
  logic [1:0]  cls;
  logic [1:0]  sel_cls;
  logic [2:0]  rbase;
  logic [15:0] sxy;

  assign frm_take  = frm_valid && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    cv_nxt = cv_r;
    for (int i = 0; i < 6; i++) cxy_nxt[i] = cxy_r[i];
    base = (frm.mode == MODE_RING) ? 3'd3 : 3'd0;
    if (frm.kind == KIND_MULTI) begin
      for (int i = 0; i < 3; i++) begin
        cv_nxt[base + 3'(i)]  = 1'b0;
        cxy_nxt[base + 3'(i)] = '0;
      end
      if (frm.count >= 2'd1 && frm.cls0 != 2'd0) begin
        cv_nxt[base + 3'(frm.cls0) - 3'd1]  = 1'b1;
        cxy_nxt[base + 3'(frm.cls0) - 3'd1] = frm.xy0;
      end
      if (frm.count >= 2'd2 && frm.cls1 != 2'd0) begin
        cv_nxt[base + 3'(frm.cls1) - 3'd1]  = 1'b1;
        cxy_nxt[base + 3'(frm.cls1) - 3'd1] = frm.xy1;
      end
      if (frm.count >= 2'd3 && frm.cls2 != 2'd0) begin
        cv_nxt[base + 3'(frm.cls2) - 3'd1]  = 1'b1;
        cxy_nxt[base + 3'(frm.cls2) - 3'd1] = frm.xy2;
      end
    end
  end

  // selection from the updated cache
  always_comb begin
    rbase = (request_mode == MODE_RING) ? 3'd3 : 3'd0;
    sel_cls = 2'd0;
    if (request_class != 2'd0) begin
      if (cv_nxt[rbase + 3'(request_class) - 3'd1]) sel_cls = request_class;
    end else if (cv_nxt[rbase]) sel_cls = 2'd1;
    else if (cv_nxt[rbase + 3'd1]) sel_cls = 2'd2;
    else if (cv_nxt[rbase + 3'd2]) sel_cls = 2'd3;
    cls = sel_cls;
    sxy = (cls == 2'd0) ? 16'd0 : cxy_nxt[rbase + 3'(cls) - 3'd1];
  end

  always_comb begin
    set_sel = 1'b0;
    so = '0;
    sx = '0;
    sy = '0;
    if (frm.kind == KIND_SINGLE) begin
      set_sel = 1'b1;
      so = frm.b2;
      sx = frm.b3;
      sy = frm.b4;
    end else if (frm.kind == KIND_MULTI && frm.b2 == {6'd0, request_mode}) begin
      set_sel = 1'b1;
      if (cls != 2'd0) begin
        so = (request_mode == MODE_RING) ? 8'(cls) + RING_ORDER_BASE - 8'd1 : 8'(cls);
        sx = sxy[15:8];
        sy = sxy[7:0];
      end
    end
    nz = so != 0 && sx != 0 && sy != 0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r    <= '0;
      for (int i = 0; i < 6; i++) cxy_r[i] <= '0;
      sel_o_r <= '0;
      sel_x_r <= '0;
      sel_y_r <= '0;
      ddx_r   <= '0;
      ddy_r   <= '0;
      adx_r   <= '0;
      ady_r   <= '0;
      ov_r    <= 1'b0;
      scale_r <= '0;
      total_r <= '0;
      lmc_r   <= '0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= frm_take || (res_valid_r && !res_ready);
      if (frm_take) begin
        cv_r <= cv_nxt;
        for (int i = 0; i < 6; i++) cxy_r[i] <= cxy_nxt[i];
        if (frm.kind == KIND_MULTI) begin
          total_r <= total_r + 32'd1;
          lmc_r   <= {frm.mode, frm.count};
        end
        if (frm.kind == KIND_SCALE) scale_r <= {frm.b3, frm.b4};
        if (set_sel) begin
          sel_o_r <= so;
          sel_x_r <= sx;
          sel_y_r <= sy;
          ov_r    <= nz;
          ddx_r   <= nz ? {1'b0, sx} - {1'b0, center_x} : 9'd0;
          ddy_r   <= nz ? {1'b0, sy} - {1'b0, center_y} : 9'd0;
          adx_r   <= nz ? {1'b0, center_x} - {1'b0, sx} : 9'd0;
          ady_r   <= nz ? {1'b0, center_y} - {1'b0, sy} : 9'd0;
        end
      end
    end
  end

  // result register reads the state as updated by this frame
  always_ff @(posedge clk) begin
    if (frm_take) begin
      res_r.frame_kind   <= frm.kind;
      res_r.target_order <= set_sel ? so : sel_o_r;
      res_r.target_x     <= set_sel ? sx : sel_x_r;
      res_r.target_y     <= set_sel ? sy : sel_y_r;
      res_r.offset_valid <= set_sel ? nz : ov_r;
      res_r.disc_dx <= set_sel ? (nz ? {1'b0, sx} - {1'b0, center_x} : 9'd0) : ddx_r;
      res_r.disc_dy <= set_sel ? (nz ? {1'b0, sy} - {1'b0, center_y} : 9'd0) : ddy_r;
      res_r.arm_dx  <= set_sel ? (nz ? {1'b0, center_x} - {1'b0, sx} : 9'd0) : adx_r;
      res_r.arm_dy  <= set_sel ? (nz ? {1'b0, center_y} - {1'b0, sy} : 9'd0) : ady_r;
      res_r.scale_raw   <= (frm.kind == KIND_SCALE) ? {frm.b3, frm.b4} : scale_r;
      res_r.frame_total <= (frm.kind == KIND_MULTI) ? total_r + 32'd1 : total_r;
    end
  end

  `VFP_ASSERT_NXT(a_take_gives_result, frm_take, res_valid_r, "frame taken without result")
  `VFP_ASSERT_NXT(a_hold_stalled, res_valid_r && !res_ready, res_valid_r && $stable(res_r), "stalled result changed")
  `VFP_ASSERT_IMP(a_offsets_zero, !ov_r, ddx_r == 9'd0 && adx_r == 9'd0, "offsets set while invalid")
  `VFP_ASSERT_NXT(a_total_step, frm_take && frm.kind == KIND_MULTI, total_r == $past(total_r) + 32'd1, "multi count missed")

endmodule

// ===== design/vision_frame_parser_target_select.sv =====
// ---------------------------------------------------------------------------
// vision_frame_parser_target_select
// camera link byte parser with per-mode target cache and selection
// ---------------------------------------------------------------------------
// out_tvalid rises after the frame passes the queue and the result register
// throughput: one byte per cycle while the frame queue is not full
// a two-entry frame queue lets the parser run while a result waits
// synchronous active-low reset clears parser state, cache, selection, counters
// and restores the centre registers to 121 and 115
module vision_frame_parser_target_select (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // rx_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // frame_kind, target_order, target_x, target_y, disc_dx, disc_dy, arm_dx,
  // arm_dy, offset_valid, scale_raw, frame_total, then zero fill
  output logic [vfp_pkg::OUT_W-1:0]   out_tdata,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [7:0]                  cfg_wdata
);
  import vfp_pkg::*;

  logic [7:0] center_x_r, center_y_r;
  logic [1:0] req_mode_r, req_cls_r;
  logic       frm_valid, q_full, q_valid, q_take;
  frame_t     frm, q_frm;
  result_t    res;

  // accept bytes only while the queue has room for a possible frame
  assign in_tready = !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= CENTER_X_RST;
      center_y_r <= CENTER_Y_RST;
      req_mode_r <= '0;
      req_cls_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X: center_x_r <= cfg_wdata;
        REG_CENTER_Y: center_y_r <= cfg_wdata;
        REG_REQ_MODE: req_mode_r <= cfg_wdata[1:0];
        REG_REQ_CLS:  req_cls_r  <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  vfp_parser u_parser (
    .clk(clk), .rst_n(rst_n),
    .byte_valid(in_tvalid && in_tready), .rx_byte(in_tdata),
    .frm_valid(frm_valid), .frm(frm)
  );

  vfp_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_en(frm_valid), .wr_data(frm), .full(q_full),
    .rd_valid(q_valid), .rd_en(q_take), .rd_data(q_frm)
  );

  vfp_decoder u_decoder (
    .clk(clk), .rst_n(rst_n),
    .frm_valid(q_valid), .frm(q_frm), .frm_take(q_take),
    .center_x(center_x_r), .center_y(center_y_r),
    .request_mode(req_mode_r), .request_class(req_cls_r),
    .res_valid(out_tvalid), .res(res), .res_ready(out_tready)
  );

  assign out_tdata = {{(OUT_W - OUT_BITS){1'b0}},
    res.frame_total, res.scale_raw, res.offset_valid, res.arm_dy, res.arm_dx,
    res.disc_dy, res.disc_dx, res.target_y, res.target_x, res.target_order,
    res.frame_kind};

endmodule

// ===== test/tb_vision_frame_parser_target_select.sv =====
// ---------------------------------------------------------------------------
// tb_vision_frame_parser_target_select
// streams camera link bytes into the frame parser and checks every result
// scoreboard follows parser, per-mode cache and selection for each transfer
// directed frames first, then random frames with noise and broken frames
// ---------------------------------------------------------------------------
module tb_vision_frame_parser_target_select;
  import vfp_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [7:0]  order;
    logic [7:0]  tx;
    logic [7:0]  ty;
    logic [8:0]  disc_dx;
    logic [8:0]  disc_dy;
    logic [8:0]  arm_dx;
    logic [8:0]  arm_dy;
    logic        off_valid;
    logic [15:0] scale;
    logic [31:0] total;
  } target_report_t;

  class frame_scoreboard;
    logic [7:0]  center_x, center_y;
    logic [1:0]  req_mode, req_class;
    bit          in_frame;
    int          idx;
    logic [7:0]  fbuf [16];
    bit          cache_valid [6];
    logic [15:0] cache_xy [6];
    logic [7:0]  sel_order, sel_x, sel_y;
    logic        off_valid;
    logic [8:0]  disc_dx, disc_dy, arm_dx, arm_dy;
    logic [15:0] scale_held;
    logic [31:0] multi_count;
    target_report_t reports_due [$];
    int          errors;

    function void clear();
      center_x = CENTER_X_RST; center_y = CENTER_Y_RST;
      req_mode = 0; req_class = 0;
      in_frame = 0; idx = 0;
      for (int i = 0; i < 6; i++) begin
        cache_valid[i] = 0; cache_xy[i] = 0;
      end
      sel_order = 0; sel_x = 0; sel_y = 0;
      off_valid = 0; disc_dx = 0; disc_dy = 0; arm_dx = 0; arm_dy = 0;
      scale_held = 0; multi_count = 0; errors = 0;
    endfunction

    function void set_reg(logic [1:0] index, logic [7:0] value);
      case (index)
        REG_CENTER_X: center_x = value;
        REG_CENTER_Y: center_y = value;
        REG_REQ_MODE: req_mode = value[1:0];
        REG_REQ_CLS:  req_class = value[1:0];
        default: ;
      endcase
    endfunction

    function void choose(logic [7:0] order, logic [7:0] x, logic [7:0] y);
      sel_order = order; sel_x = x; sel_y = y;
      off_valid = (order != 0) && (x != 0) && (y != 0);
      if (off_valid) begin
        disc_dx = {1'b0, x} - {1'b0, center_x};
        disc_dy = {1'b0, y} - {1'b0, center_y};
        arm_dx  = {1'b0, center_x} - {1'b0, x};
        arm_dy  = {1'b0, center_y} - {1'b0, y};
      end else begin
        disc_dx = 0; disc_dy = 0; arm_dx = 0; arm_dy = 0;
      end
    endfunction

    function void pick_from_cache();
      int base;
      int cls;
      base = (req_mode == MODE_RING) ? 3 : 0;
      cls = 0;
      if (req_class != 0) begin
        if (cache_valid[base + int'(req_class) - 1]) cls = int'(req_class);
      end else begin
        for (int c = 3; c >= 1; c--)
          if (cache_valid[base + c - 1]) cls = c;
      end
      if (cls == 0) choose(8'd0, 8'd0, 8'd0);
      else choose((req_mode == MODE_RING) ? 8'(cls + int'(RING_ORDER_BASE) - 1) : 8'(cls),
                  cache_xy[base + cls - 1][15:8], cache_xy[base + cls - 1][7:0]);
    endfunction

    // decode a complete frame, returns 0 when no result is due
    function bit decode(output kind_t kind);
      int base, count, cls;
      logic [7:0] mode;
      kind = KIND_SINGLE;
      if (fbuf[1] == TYPE_SINGLE) begin
        choose(fbuf[2], fbuf[3], fbuf[4]);
        return 1;
      end
      if (fbuf[1] == TYPE_SCALE) begin
        kind = KIND_SCALE;
        scale_held = {fbuf[3], fbuf[4]};
        return 1;
      end
      if (fbuf[1] != TYPE_MULTI) return 0;
      mode = fbuf[2];
      if (mode != MODE_MATERIAL && mode != MODE_RING) return 0;
      kind = KIND_MULTI;
      count = int'(fbuf[3]);
      base = (mode == MODE_RING) ? 3 : 0;
      for (int i = 0; i < 3; i++) begin
        cache_valid[base + i] = 0; cache_xy[base + i] = 0;
      end
      multi_count++;
      for (int i = 0; i < count; i++) begin
        cls = int'(fbuf[4 + i * 3]);
        if (cls >= 1 && cls <= 3) begin
          cache_valid[base + cls - 1] = 1;
          cache_xy[base + cls - 1] = {fbuf[5 + i * 3], fbuf[6 + i * 3]};
        end
      end
      if (mode == req_mode) pick_from_cache();
      return 1;
    endfunction

    function void note_byte(logic [7:0] b);
      bit ready;
      kind_t kind;
      target_report_t r;
      if (b == HDR_BYTE && !in_frame) begin
        in_frame = 1; idx = 0;
      end
      if (!in_frame) return;
      if (idx < 16) fbuf[idx] = b;
      idx++;
      if (idx >= RX_BUFFER_BYTES) begin
        in_frame = 0; idx = 0; return;
      end
      if (idx < 2) return;
      if (fbuf[1] == TYPE_MULTI) begin
        if (idx < 4) return;
        if (fbuf[3] > MAX_TARGETS) begin
          in_frame = 0; idx = 0; return;
        end
        ready = idx >= 5 + int'(fbuf[3]) * 3;
      end else if (fbuf[1] == TYPE_SINGLE || fbuf[1] == TYPE_SCALE) begin
        ready = idx >= 6;
      end else begin
        ready = (b == END_BYTE);
      end
      if (!ready) return;
      in_frame = 0; idx = 0;
      if (b != END_BYTE) return;
      if (!decode(kind)) return;
      r.kind = kind; r.order = sel_order; r.tx = sel_x; r.ty = sel_y;
      r.disc_dx = disc_dx; r.disc_dy = disc_dy; r.arm_dx = arm_dx; r.arm_dy = arm_dy;
      r.off_valid = off_valid; r.scale = scale_held; r.total = multi_count;
      reports_due.push_back(r);
    endfunction

    function void field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] d);
      target_report_t r;
      if (reports_due.size() == 0) begin
        $error("result transfer with nothing expected: %h", d);
        errors++;
        return;
      end
      r = reports_due.pop_front();
      field("frame_kind",   32'(r.kind),      32'(d[1:0]));
      field("target_order", 32'(r.order),     32'(d[9:2]));
      field("target_x",     32'(r.tx),        32'(d[17:10]));
      field("target_y",     32'(r.ty),        32'(d[25:18]));
      field("disc_dx",      32'(r.disc_dx),   32'(d[34:26]));
      field("disc_dy",      32'(r.disc_dy),   32'(d[43:35]));
      field("arm_dx",       32'(r.arm_dx),    32'(d[52:44]));
      field("arm_dy",       32'(r.arm_dy),    32'(d[61:53]));
      field("offset_valid", 32'(r.off_valid), 32'(d[62]));
      field("scale_raw",    32'(r.scale),     32'(d[78:63]));
      field("frame_total",  r.total,          d[110:79]);
    endfunction
  endclass

  localparam int STALL_LIMIT = 5000;

  logic             clk, rst_n;
  logic             in_tvalid, in_tready;
  logic [7:0]       in_tdata;
  logic             out_tvalid, out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [7:0]       cfg_wdata;

  frame_scoreboard sb = new();
  int  bytes_in;
  int  stall_cycles;
  bit  gaps_on;

  vision_frame_parser_target_select u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // input byte tracking, result checking, back-pressure and the stall watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
      stall_cycles <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        sb.note_byte(in_tdata);
        bytes_in = bytes_in + 1;
      end
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("vision_frame_parser_target_select: mismatch");
        $finish;
      end
      out_tready <= !(gaps_on && $urandom_range(99) < 14);
    end
  end

  task automatic send_byte(logic [7:0] b);
    int target;
    if (gaps_on && $urandom_range(99) < 14) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tdata  <= b;
    in_tvalid <= 1;
    target = bytes_in + 1;
    @(posedge clk);
    wait (bytes_in == target);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.reports_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // all four registers written back to back while the block is idle
  task automatic set_config(logic [7:0] cx, logic [7:0] cy, logic [1:0] mode,
                            logic [1:0] cls);
    logic [7:0] vals [4];
    vals = '{cx, cy, {6'd0, mode}, {6'd0, cls}};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1; cfg_index <= i[1:0]; cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(i[1:0], vals[i]);
    end
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] any_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] class_byte();
    return ($urandom_range(9) == 0) ? any_byte() : 8'($urandom_range(3));
  endfunction

  task automatic send_tail(logic [7:0] a, logic [7:0] b, logic [7:0] c, bit good_end);
    send_byte(a); send_byte(b); send_byte(c);
    send_byte(good_end ? END_BYTE : any_byte());
  endtask

  task automatic send_multi(logic [7:0] mode, int count, bit good_end);
    send_byte(HDR_BYTE); send_byte(TYPE_MULTI); send_byte(mode); send_byte(8'(count));
    for (int i = 0; i < count; i++) begin
      send_byte(class_byte()); send_byte(any_byte()); send_byte(any_byte());
    end
    send_byte(good_end ? END_BYTE : any_byte());
  endtask

  task automatic random_frame();
    int pick;
    logic [7:0] t;
    bit ok;
    pick = int'($urandom_range(99));
    ok = $urandom_range(19) != 0;
    if (pick < 35) begin
      send_multi(($urandom_range(9) == 0) ? any_byte() : 8'($urandom_range(1, 2)),
                 int'($urandom_range(3)), ok);
    end else if (pick < 55) begin
      send_byte(HDR_BYTE); send_byte(TYPE_SINGLE);
      send_tail(any_byte(), any_byte(), any_byte(), ok);
    end else if (pick < 67) begin
      send_byte(HDR_BYTE); send_byte(TYPE_SCALE);
      send_tail(any_byte(), any_byte(), any_byte(), ok);
    end else if (pick < 75) begin
      // unknown type, ends at the first end byte
      t = any_byte();
      send_byte(HDR_BYTE); send_byte(t);
      repeat ($urandom_range(0, 5)) send_byte(any_byte());
      send_byte(END_BYTE);
    end else if (pick < 80) begin
      send_byte(HDR_BYTE); send_byte(TYPE_MULTI);
      send_byte(8'($urandom_range(1, 2))); send_byte(8'($urandom_range(4, 255)));
    end else if (pick < 82 && $urandom_range(3) == 0) begin
      // overflow: long frame of unknown type with no end byte
      send_byte(HDR_BYTE); send_byte(8'h00);
      repeat (RX_BUFFER_BYTES + 2) send_byte(8'($urandom_range(0, 8'hA9)));
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(any_byte());
    end
  endtask

  initial begin
    rst_n = 0; in_tvalid = 0; in_tdata = 0; out_tready = 0;
    cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    bytes_in = 0; gaps_on = 1;
    sb.clear();
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: single with header byte inside, zero target, scale, scale with bad end byte, unknown type, multi
    send_byte(HDR_BYTE); send_byte(TYPE_SINGLE); send_tail(8'h01, HDR_BYTE, 8'hFF, 1);
    send_byte(HDR_BYTE); send_byte(TYPE_SINGLE); send_tail(8'h00, 8'h10, 8'h20, 1);
    send_byte(HDR_BYTE); send_byte(TYPE_SCALE); send_tail(8'h00, 8'hFF, 8'hFF, 1);
    send_byte(HDR_BYTE); send_byte(TYPE_SCALE); send_tail(8'h12, 8'h34, 8'h56, 0);
    send_byte(HDR_BYTE); send_byte(8'h77); send_byte(END_BYTE);
    drain();
    set_config(8'd0, 8'd255, MODE_RING, 2'd0);
    send_multi({6'd0, MODE_RING}, 3, 1);
    send_multi(8'd3, 0, 1);
    send_byte(HDR_BYTE); send_byte(TYPE_MULTI); send_byte({6'd0, MODE_MATERIAL});
    send_byte(8'd4);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_config(8'd255, 8'd0, MODE_MATERIAL, 2'd1);
        1: set_config(CENTER_X_RST, CENTER_Y_RST, MODE_RING, 2'd3);
        2: set_config(8'd0, 8'd0, 2'd0, 2'd0);
        3: set_config(8'd255, 8'd255, MODE_RING, 2'd2);
        4: set_config(8'($urandom_range(255)), 8'($urandom_range(255)), MODE_MATERIAL, 2'd0);
        5: set_config(8'($urandom_range(255)), 8'($urandom_range(255)), MODE_RING, 2'd1);
        6: set_config(8'd128, 8'd1, MODE_MATERIAL, 2'd3);
        default: set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                            2'($urandom_range(2)), 2'($urandom_range(3)));
      endcase
      gaps_on = (phase != 3);
      while (bytes_in < 240 * (phase + 1)) random_frame();
      drain();
    end

    if (sb.errors == 0) begin
      $display("vision_frame_parser_target_select: match");
    end else begin
      $display("vision_frame_parser_target_select: mismatch");
    end
    $finish;
  end

endmodule
